FILE: hw/rtl/jsu_pkg.sv
// Shared types and constants for the JSON string unescaper.
// No dependencies; compiled first.
package jsu_pkg;

   typedef enum logic [2:0] {
      MODE_PLAIN = 3'd0,
      MODE_ESC   = 3'd1,
      MODE_HEX1  = 3'd2,
      MODE_BSL   = 3'd3,
      MODE_U     = 3'd4,
      MODE_HEX2  = 3'd5
   } mode_type;

   typedef enum logic [2:0] {
      ST_BYTE  = 3'd0,
      ST_END   = 3'd1,
      ST_MISSQ = 3'd2,
      ST_ESC   = 3'd3,
      ST_CHAR  = 3'd4,
      ST_HEX   = 3'd5,
      ST_SURR  = 3'd6
   } status_type;

   localparam int MAX_RESULTS = 4;

   // One input item's worth of results: count 0..4, shared status
   typedef struct packed {
      logic [2:0]                  count;
      status_type                  status;
      logic [MAX_RESULTS-1:0][7:0] data;
   } group_type;

   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_BSL   = 8'h5C;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_B     = 8'h62;
   localparam logic [7:0] CH_F     = 8'h66;
   localparam logic [7:0] CH_N     = 8'h6E;
   localparam logic [7:0] CH_R     = 8'h72;
   localparam logic [7:0] CH_T     = 8'h74;
   localparam logic [7:0] CH_U     = 8'h75;
   localparam logic [7:0] CH_SPACE = 8'h20;

   localparam logic [15:0] HI_SURR_MIN = 16'hD800;
   localparam logic [15:0] HI_SURR_MAX = 16'hDBFF;
   localparam logic [15:0] LO_SURR_MIN = 16'hDC00;
   localparam logic [15:0] LO_SURR_MAX = 16'hDFFF;

endpackage

FILE: hw/rtl/jsu_req_if.sv
// Input byte channel of the JSON string unescaper.
// Depends on nothing.
interface jsu_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;

   modport source (output valid, output in_byte, input ready);
   modport sink   (input valid, input in_byte, output ready);
endinterface

FILE: hw/rtl/jsu_rsp_if.sv
// Result channel of the JSON string unescaper.
// Depends on nothing.
interface jsu_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic [2:0] status;
   logic       last;

   modport source (output valid, output out_byte, output status, output last, input ready);
   modport sink   (input valid, input out_byte, input status, input last, output ready);
endinterface

FILE: hw/rtl/jsu_decode.sv
// Escape decoder: mode/hex state plus the per-byte decode and UTF-8 encode.
// Depends on jsu_pkg.
module jsu_decode
   import jsu_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       fire,
   input  logic [7:0] in_byte,
   output group_type  grp
);

   mode_type    mode_ff, mode_in;
   logic [15:0] hv_ff, hv_in;
   logic [1:0]  hc_ff, hc_in;
   logic [9:0]  hs_ff, hs_in;

   logic        dig_ok;
   logic [3:0]  dig;
   logic [15:0] hex_new;
   logic [20:0] pair_cp;

   function automatic logic [4:0] hexdig(input logic [7:0] c);
      logic [4:0] r;
      r = '0;
      if (c >= 8'h30 && c <= 8'h39) r = {1'b1, 4'(c - 8'h30)};
      else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, 4'(c - 8'h37)};
      else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, 4'(c - 8'h57)};
      return r;
   endfunction

   function automatic group_type utf8_enc(input logic [20:0] cp);
      group_type g;
      g = '0;
      g.status = ST_BYTE;
      if (cp <= 21'h7F) begin
         g.count   = 3'd1;
         g.data[0] = cp[7:0];
      end else if (cp <= 21'h7FF) begin
         g.count   = 3'd2;
         g.data[0] = {3'b110, cp[10:6]};
         g.data[1] = {2'b10, cp[5:0]};
      end else if (cp <= 21'hFFFF) begin
         g.count   = 3'd3;
         g.data[0] = {4'b1110, cp[15:12]};
         g.data[1] = {2'b10, cp[11:6]};
         g.data[2] = {2'b10, cp[5:0]};
      end else begin
         g.count   = 3'd4;
         g.data[0] = {5'b11110, cp[20:18]};
         g.data[1] = {2'b10, cp[17:12]};
         g.data[2] = {2'b10, cp[11:6]};
         g.data[3] = {2'b10, cp[5:0]};
      end
      return g;
   endfunction

   function automatic group_type one(input logic [7:0] b, input status_type st);
      group_type g;
      g = '0;
      g.count   = 3'd1;
      g.status  = st;
      g.data[0] = b;
      return g;
   endfunction

   assign {dig_ok, dig} = hexdig(in_byte);
   assign hex_new       = {hv_ff[11:0], dig};
   assign pair_cp       = {1'b0, hs_ff, hex_new[9:0]} + 21'h10000;

   always_comb begin
      mode_in = mode_ff;
      hv_in   = hv_ff;
      hc_in   = hc_ff;
      hs_in   = hs_ff;
      grp     = '0;
      grp.status = ST_BYTE;
      case (mode_ff)
         MODE_ESC: begin
            mode_in = MODE_PLAIN;
            case (in_byte)
               CH_QUOTE: grp = one(CH_QUOTE, ST_BYTE);
               CH_BSL:   grp = one(CH_BSL, ST_BYTE);
               CH_SLASH: grp = one(CH_SLASH, ST_BYTE);
               CH_B:     grp = one(8'h08, ST_BYTE);
               CH_F:     grp = one(8'h0C, ST_BYTE);
               CH_N:     grp = one(8'h0A, ST_BYTE);
               CH_R:     grp = one(8'h0D, ST_BYTE);
               CH_T:     grp = one(8'h09, ST_BYTE);
               CH_U: begin
                  mode_in = MODE_HEX1;
                  hv_in   = '0;
                  hc_in   = '0;
               end
               default:  grp = one(8'h00, ST_ESC);
            endcase
         end
         MODE_HEX1, MODE_HEX2: begin
            if (!dig_ok) begin
               grp     = one(8'h00, ST_HEX);
               mode_in = MODE_PLAIN;
            end else begin
               hv_in = hex_new;
               if (hc_ff != 2'd3) begin
                  hc_in = hc_ff + 2'd1;
               end else begin
                  hc_in   = '0;
                  mode_in = MODE_PLAIN;
                  if (mode_ff == MODE_HEX1) begin
                     if (hex_new >= HI_SURR_MIN && hex_new <= HI_SURR_MAX) begin
                        hs_in   = hex_new[9:0];
                        mode_in = MODE_BSL;
                     end else begin
                        grp = utf8_enc({5'd0, hex_new});
                     end
                  end else if (hex_new < LO_SURR_MIN || hex_new > LO_SURR_MAX) begin
                     grp = one(8'h00, ST_SURR);
                  end else begin
                     grp = utf8_enc(pair_cp);
                  end
               end
            end
         end
         MODE_BSL: begin
            if (in_byte != CH_BSL) begin
               grp     = one(8'h00, ST_SURR);
               mode_in = MODE_PLAIN;
            end else begin
               mode_in = MODE_U;
            end
         end
         MODE_U: begin
            if (in_byte != CH_U) begin
               grp     = one(8'h00, ST_SURR);
               mode_in = MODE_PLAIN;
            end else begin
               mode_in = MODE_HEX2;
               hv_in   = '0;
               hc_in   = '0;
            end
         end
         default: begin
            mode_in = MODE_PLAIN;
            if (in_byte == CH_QUOTE)      grp = one(8'h00, ST_END);
            else if (in_byte == CH_BSL)   mode_in = MODE_ESC;
            else if (in_byte == 8'h00)    grp = one(8'h00, ST_MISSQ);
            else if (in_byte < CH_SPACE)  grp = one(8'h00, ST_CHAR);
            else                          grp = one(in_byte, ST_BYTE);
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_PLAIN;
         hv_ff   <= '0;
         hc_ff   <= '0;
         hs_ff   <= '0;
      end else if (fire) begin
         mode_ff <= mode_in;
         hv_ff   <= hv_in;
         hc_ff   <= hc_in;
         hs_ff   <= hs_in;
      end
   end

   // any error or end result drops back to the plain body
   a_err_to_plain: assert property (@(posedge clock) disable iff (reset)
      fire && grp.count != 3'd0 && grp.status != ST_BYTE |=> mode_ff == MODE_PLAIN)
      else $error("decoder not back in plain body after end/error");

   // a low-surrogate wait state only follows a high surrogate
   a_bsl_entry: assert property (@(posedge clock) disable iff (reset)
      fire && mode_in == MODE_BSL && mode_ff != MODE_BSL |-> grp.count == 3'd0)
      else $error("results emitted while entering surrogate wait");

endmodule

FILE: hw/rtl/jsu_outq.sv
// Result buffer: current group plus one waiting group, shifted out one byte per item.
// Depends on jsu_pkg.
module jsu_outq
   import jsu_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        load,
   input  group_type   grp,
   output logic        can_load,
   jsu_rsp_if.source   rsp
);

   group_type  cur_ff, cur_in;
   group_type  nxt_ff, nxt_in;
   logic       nxt_v_ff, nxt_v_in;
   logic [2:0] remain_ff, remain_in;
   logic [1:0] idx_ff, idx_in;
   logic       take;
   logic       cur_done;

   assign take     = rsp.valid && rsp.ready;
   assign cur_done = (remain_ff == 3'd0) || (remain_ff == 3'd1 && take);
   assign can_load = !nxt_v_ff;

   assign rsp.valid    = remain_ff != 3'd0;
   assign rsp.out_byte = cur_ff.data[idx_ff];
   assign rsp.status   = cur_ff.status;
   assign rsp.last     = remain_ff == 3'd1;

   always_comb begin
      cur_in    = cur_ff;
      nxt_in    = nxt_ff;
      nxt_v_in  = nxt_v_ff;
      remain_in = remain_ff;
      idx_in    = idx_ff;
      if (cur_done) begin
         if (nxt_v_ff) begin
            cur_in    = nxt_ff;
            remain_in = nxt_ff.count;
            idx_in    = '0;
            nxt_v_in  = load;
            if (load) nxt_in = grp;
         end else if (load) begin
            cur_in    = grp;
            remain_in = grp.count;
            idx_in    = '0;
         end else begin
            remain_in = '0;
         end
      end else begin
         if (take) begin
            remain_in = remain_ff - 3'd1;
            idx_in    = idx_ff + 2'd1;
         end
         if (load) begin
            nxt_in   = grp;
            nxt_v_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         remain_ff <= '0;
         idx_ff    <= '0;
         nxt_v_ff  <= 1'b0;
      end else begin
         remain_ff <= remain_in;
         idx_ff    <= idx_in;
         nxt_v_ff  <= nxt_v_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      nxt_ff <= nxt_in;
   end

   a_nxt_behind_cur: assert property (@(posedge clock) disable iff (reset)
      nxt_v_ff |-> remain_ff != 3'd0)
      else $error("waiting group held while current slot empty");

   a_err_single: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.status != ST_BYTE |-> rsp.last)
      else $error("end/error item not marked last");

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      load |-> !nxt_v_ff)
      else $error("group loaded with both slots full");

   a_drain: assert property (@(posedge clock) disable iff (reset)
      take && rsp.last && !nxt_v_ff && !load |=> !rsp.valid)
      else $error("result channel valid after final item drained");

endmodule

FILE: hw/rtl/json_string_unescape.sv
// Top level of the JSON string unescaper: decoder plus result buffer.
// Depends on jsu_pkg, jsu_req_if, jsu_rsp_if, jsu_decode, jsu_outq.
//
//  channel | dir | payload                         | item
//  --------+-----+---------------------------------+-------------------------------
//  req     | in  | in_byte[7:0]                    | one raw byte of a string body
//  rsp     | out | out_byte[7:0] status[2:0] last  | one decoded byte or end/error
//
//  One input byte is taken per clock while the waiting-group slot is free.
//  Each byte yields 0..4 result items, presented one per clock from a
//  registered buffer while rsp.ready is high; a code point that encodes to N
//  UTF-8 bytes yields N items, and the buffer drains one item per cycle while rsp.ready is high.
//  First result appears the cycle after its byte is accepted when no earlier
//  group is still draining; otherwise it follows right behind that group.
//  req.ready depends only on registered state, never on rsp.ready.
//  Synchronous active-high reset returns to the plain-body mode and empties
//  the buffer; after an end or error result the next byte starts a new string.
module json_string_unescape
   import jsu_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   jsu_req_if.sink    req,
   jsu_rsp_if.source  rsp
);

   group_type grp;
   logic      fire;
   logic      can_load;

   // accepted byte: decode state advances now, results go to the buffer
   assign req.ready = can_load;
   assign fire      = req.valid && req.ready;

   jsu_decode u_decode (
      .clock   (clock),
      .reset   (reset),
      .fire    (fire),
      .in_byte (req.in_byte),
      .grp     (grp)
   );

   // bytes that only advance the escape state produce an empty group
   jsu_outq u_outq (
      .clock    (clock),
      .reset    (reset),
      .load     (fire && grp.count != 3'd0),
      .grp      (grp),
      .can_load (can_load),
      .rsp      (rsp)
   );

endmodule

FILE: bench/testbench.sv
// Self-checking bench for json_string_unescape: random and directed string bodies in,
// decoded UTF-8 bytes and end/error codes out, checked against an in-bench decoder.
// Depends on jsu_pkg, jsu_req_if, jsu_rsp_if and the json_string_unescape RTL.
`timescale 1ns / 100ps

module testbench;
   import jsu_pkg::*;

   // Number of random body bytes after the directed part
   localparam int RANDOM_BYTES = 300;
   // Cycles with no handshake on either side before the run is declared hung.
   // The slowest correct stretch is a sender gap or a sink stall.
   localparam int HANG_LIMIT = 1000;
   // Settling time after the last expected result has been taken
   localparam int TAIL_CYCLES = 20;

   // One decoded result as it should leave the block
   typedef struct packed {
      logic [7:0] data;
      status_type status;
      logic       last;
   } utf8_item_type;

   // One raw body byte; hold marks a byte that waits until all results are out
   typedef struct {
      logic [7:0] data;
      bit         hold;
   } body_byte_type;

   logic clock = 1'b0;
   logic reset;

   jsu_req_if req_ch ();
   jsu_rsp_if rsp_ch ();

   json_string_unescape u_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   body_byte_type body_q[$];     // bytes waiting to be sent
   utf8_item_type decoded_q[$];  // decoded results waiting to come out
   bit            mark_hold;     // next pushed byte waits for the pipe to drain
   int            total_bytes;
   int            bytes_taken;
   int            error_count;

   // Decoder state, mirrors the block's
   mode_type    dec_mode;
   logic [15:0] hex_acc;
   logic [1:0]  hex_cnt;
   logic [15:0] hi_surr;

   task automatic note_error(input string msg);
      error_count++;
      $display("ERROR @%0t: %s", $time, msg);
   endtask

   // ---------------------------------------------------------------------------
   // Decoder
   // ---------------------------------------------------------------------------
   function automatic int hex_nibble(input logic [7:0] c);
      if (c >= "0" && c <= "9") return int'(c - "0");
      if (c >= "A" && c <= "F") return int'(c - "A") + 10;
      if (c >= "a" && c <= "f") return int'(c - "a") + 10;
      return -1;
   endfunction

   task automatic push_out(input logic [7:0] data, input logic last);
      utf8_item_type item;
      item      = '{data: data, status: ST_BYTE, last: last};
      decoded_q = {decoded_q, item};
   endtask

   // End of string and every error: single item, data 0, back to plain body
   task automatic push_status(input status_type st);
      utf8_item_type item;
      item      = '{data: 8'h00, status: st, last: 1'b1};
      decoded_q = {decoded_q, item};
      dec_mode  = MODE_PLAIN;
   endtask

   task automatic emit_utf8(input logic [20:0] cp);
      if (cp <= 21'h7F) begin
         push_out(cp[7:0], 1'b1);
      end else if (cp <= 21'h7FF) begin
         push_out({3'b110, cp[10:6]}, 1'b0);
         push_out({2'b10, cp[5:0]}, 1'b1);
      end else if (cp <= 21'hFFFF) begin
         push_out({4'b1110, cp[15:12]}, 1'b0);
         push_out({2'b10, cp[11:6]}, 1'b0);
         push_out({2'b10, cp[5:0]}, 1'b1);
      end else begin
         push_out({5'b11110, cp[20:18]}, 1'b0);
         push_out({2'b10, cp[17:12]}, 1'b0);
         push_out({2'b10, cp[11:6]}, 1'b0);
         push_out({2'b10, cp[5:0]}, 1'b1);
      end
   endtask

   // Consume one body byte, queue the results it causes
   task automatic unescape_byte(input logic [7:0] c);
      int          digit;
      logic [20:0] cp;
      digit = hex_nibble(c);
      case (dec_mode)
         MODE_ESC: begin
            dec_mode = MODE_PLAIN;
            case (c)
               CH_QUOTE, CH_BSL, CH_SLASH: push_out(c, 1'b1);
               CH_B: push_out(8'h08, 1'b1);
               CH_F: push_out(8'h0C, 1'b1);
               CH_N: push_out(8'h0A, 1'b1);
               CH_R: push_out(8'h0D, 1'b1);
               CH_T: push_out(8'h09, 1'b1);
               CH_U: begin
                  dec_mode = MODE_HEX1;
                  hex_acc  = '0;
                  hex_cnt  = '0;
               end
               default: push_status(ST_ESC);
            endcase
         end
         MODE_HEX1, MODE_HEX2: begin
            if (digit < 0) begin
               push_status(ST_HEX);
            end else begin
               hex_acc = {hex_acc[11:0], digit[3:0]};
               if (hex_cnt != 2'd3) begin
                  hex_cnt++;
               end else begin
                  hex_cnt = '0;
                  if (dec_mode == MODE_HEX1) begin
                     if (hex_acc >= HI_SURR_MIN && hex_acc <= HI_SURR_MAX) begin
                        hi_surr  = hex_acc;
                        dec_mode = MODE_BSL;
                     end else begin
                        // lone low surrogates land here too: plain 3-byte form
                        dec_mode = MODE_PLAIN;
                        emit_utf8({5'd0, hex_acc});
                     end
                  end else if (hex_acc < LO_SURR_MIN || hex_acc > LO_SURR_MAX) begin
                     push_status(ST_SURR);
                  end else begin
                     // both surrogates carry 10 payload bits in their low bits
                     dec_mode = MODE_PLAIN;
                     cp = {1'b0, hi_surr[9:0], hex_acc[9:0]} + 21'h10000;
                     emit_utf8(cp);
                  end
               end
            end
         end
         MODE_BSL: begin
            if (c != CH_BSL) push_status(ST_SURR);
            else dec_mode = MODE_U;
         end
         MODE_U: begin
            if (c != CH_U) begin
               push_status(ST_SURR);
            end else begin
               dec_mode = MODE_HEX2;
               hex_acc  = '0;
               hex_cnt  = '0;
            end
         end
         default: begin
            dec_mode = MODE_PLAIN;
            if (c == CH_QUOTE) push_status(ST_END);
            else if (c == CH_BSL) dec_mode = MODE_ESC;
            else if (c == 8'h00) push_status(ST_MISSQ);
            else if (c < CH_SPACE) push_status(ST_CHAR);
            else push_out(c, 1'b1);
         end
      endcase
   endtask

   // ---------------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------------
   task automatic push_byte(input logic [7:0] data);
      body_byte_type item;
      item      = '{data: data, hold: mark_hold};
      body_q    = {body_q, item};
      mark_hold = 1'b0;
   endtask

   // Hex digit with random letter case
   function automatic logic [7:0] hex_char(input logic [3:0] n);
      if (n < 10) return "0" + n;
      return 8'(($urandom_range(0, 1) ? "a" : "A") + n - 10);
   endfunction

   task automatic push_u4(input logic [15:0] v);
      push_byte(CH_BSL);
      push_byte(CH_U);
      for (int i = 3; i >= 0; i--)
         push_byte(hex_char(v[i*4 +: 4]));
   endtask

   // Any byte that is not a hex digit
   function automatic logic [7:0] non_hex();
      logic [7:0] b;
      b = 8'($urandom_range(0, 255));
      if (hex_nibble(b) >= 0) b = "z";
      return b;
   endfunction

   // Random per-item wait; calm stretches draw no wait at all
   function automatic int draw_wait(inout bit calm);
      if ($urandom_range(0, 24) == 0) calm = !calm;
      return calm ? 0 : $urandom_range(0, 19);
   endfunction

   // ---------------------------------------------------------------------------
   // Driver: one body byte per item, random gaps, occasional drain pause
   // ---------------------------------------------------------------------------
   int            send_gap;
   bit            send_calm;
   body_byte_type next_byte;

   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid   <= 1'b0;
         req_ch.in_byte <= '0;
         send_gap       = 0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            unescape_byte(req_ch.in_byte);
            bytes_taken++;
            send_gap = draw_wait(send_calm);
         end
         if (req_ch.valid && !req_ch.ready) begin
            // item still on offer, keep it steady
         end else if (send_gap > 0) begin
            send_gap--;
            req_ch.valid <= 1'b0;
         end else if (body_q.size() != 0 && !(body_q[0].hold && decoded_q.size() != 0)) begin
            next_byte = body_q.pop_front();
            req_ch.valid   <= 1'b1;
            req_ch.in_byte <= next_byte.data;
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Monitor: random back-pressure, field-by-field check against the oldest
   // decoded result
   // ---------------------------------------------------------------------------
   int            sink_stall;
   bit            sink_calm;
   utf8_item_type want;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         sink_stall   = 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (decoded_q.size() == 0) begin
               note_error($sformatf("unexpected result: byte %02h status %0d last %0b",
                                    rsp_ch.out_byte, rsp_ch.status, rsp_ch.last));
            end else begin
               want = decoded_q.pop_front();
               if (rsp_ch.out_byte !== want.data)
                  note_error($sformatf("out_byte %02h, expected %02h",
                                       rsp_ch.out_byte, want.data));
               if (rsp_ch.status !== want.status)
                  note_error($sformatf("status %0d, expected %s",
                                       rsp_ch.status, want.status.name()));
               if (rsp_ch.last !== want.last)
                  note_error($sformatf("last %0b, expected %0b", rsp_ch.last, want.last));
            end
            sink_stall = draw_wait(sink_calm);
         end
         if (sink_stall > 0) begin
            sink_stall--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Watchdog: no handshake on either side for too long means a hang
   // ---------------------------------------------------------------------------
   int quiet_cycles;

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= HANG_LIMIT) begin
            $display("watchdog: no item moved for %0d cycles", HANG_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Stimulus, reset and end of run
   // ---------------------------------------------------------------------------
   initial begin
      logic [7:0]  b;
      logic [15:0] v;
      int          kind;
      int          directed_n;

      req_ch.valid   = 1'b0;
      req_ch.in_byte = '0;
      rsp_ch.ready   = 1'b0;
      reset          = 1'b1;
      dec_mode       = MODE_PLAIN;
      hex_acc        = '0;
      hex_cnt        = '0;
      hi_surr        = '0;
      mark_hold      = 1'b0;
      bytes_taken    = 0;
      error_count    = 0;
      send_calm      = 1'b0;
      sink_calm      = 1'b0;

      // Directed: plain byte, top plain byte, control byte, NUL (missing quote),
      // NUL after backslash, surrogate pair to U+1F600, non-hex digit, end.
      push_byte("A");
      push_byte(8'hFF);
      push_byte(8'h1F);
      push_byte(8'h00);
      push_byte(CH_BSL);
      push_byte(8'h00);
      push_byte(CH_BSL); push_byte(CH_U);
      push_byte("D"); push_byte("8"); push_byte("3"); push_byte("D");
      push_byte(CH_BSL); push_byte(CH_U);
      push_byte("d"); push_byte("e"); push_byte("0"); push_byte("0");
      push_byte(CH_BSL); push_byte(CH_U);
      push_byte("f"); push_byte("F"); push_byte("g");
      push_byte(CH_QUOTE);
      directed_n = body_q.size();

      // Random strings: mostly well-formed content, some broken escapes
      mark_hold = 1'b1;
      while (body_q.size() < directed_n + RANDOM_BYTES) begin
         if ($urandom_range(0, 14) == 0) mark_hold = 1'b1;
         repeat ($urandom_range(0, 8)) begin
            kind = $urandom_range(0, 99);
            if (kind < 40) begin
               // plain printable or high byte
               b = 8'($urandom_range(32, 255));
               if (b == CH_QUOTE || b == CH_BSL) b = "~";
               push_byte(b);
            end else if (kind < 55) begin
               // two-character escape
               push_byte(CH_BSL);
               case ($urandom_range(0, 7))
                  0: push_byte(CH_QUOTE);
                  1: push_byte(CH_BSL);
                  2: push_byte(CH_SLASH);
                  3: push_byte(CH_B);
                  4: push_byte(CH_F);
                  5: push_byte(CH_N);
                  6: push_byte(CH_R);
                  default: push_byte(CH_T);
               endcase
            end else if (kind < 75) begin
               // \uXXXX outside the high-surrogate range
               case ($urandom_range(0, 4))
                  0: v = 16'($urandom_range(16'h0000, 16'h007F));
                  1: v = 16'($urandom_range(16'h0080, 16'h07FF));
                  2: begin
                     v = 16'($urandom_range(16'h0800, 16'hFFFF));
                     if (v >= HI_SURR_MIN && v <= HI_SURR_MAX) v ^= 16'h4000;
                  end
                  3: v = 16'($urandom_range(LO_SURR_MIN, LO_SURR_MAX));  // lone low half
                  default: begin
                     case ($urandom_range(0, 5))
                        0: v = 16'h0000;
                        1: v = 16'h007F;
                        2: v = 16'h0080;
                        3: v = 16'h07FF;
                        4: v = 16'h0800;
                        default: v = 16'hFFFF;
                     endcase
                  end
               endcase
               push_u4(v);
            end else if (kind < 90) begin
               // well-formed surrogate pair
               push_u4(16'($urandom_range(HI_SURR_MIN, HI_SURR_MAX)));
               push_u4(16'($urandom_range(LO_SURR_MIN, LO_SURR_MAX)));
            end else begin
               case ($urandom_range(0, 6))
                  0: push_byte(8'($urandom_range(1, 31)));  // control byte
                  1: begin
                     // unknown escape letter, NUL possible
                     b = 8'($urandom_range(0, 255));
                     case (b)
                        CH_QUOTE, CH_BSL, CH_SLASH, CH_B, CH_F, CH_N, CH_R, CH_T, CH_U:
                           b = "x";
                        default: ;
                     endcase
                     push_byte(CH_BSL);
                     push_byte(b);
                  end
                  2: begin
                     // non-hex digit in the first group
                     push_byte(CH_BSL);
                     push_byte(CH_U);
                     repeat ($urandom_range(0, 3))
                        push_byte(hex_char(4'($urandom_range(0, 15))));
                     push_byte(non_hex());
                  end
                  3: begin
                     // high half, then no backslash
                     push_u4(16'($urandom_range(HI_SURR_MIN, HI_SURR_MAX)));
                     b = 8'($urandom_range(0, 255));
                     if (b == CH_BSL) b = "A";
                     push_byte(b);
                  end
                  4: begin
                     // high half, backslash, then no 'u'
                     push_u4(16'($urandom_range(HI_SURR_MIN, HI_SURR_MAX)));
                     push_byte(CH_BSL);
                     b = 8'($urandom_range(0, 255));
                     if (b == CH_U) b = "n";
                     push_byte(b);
                  end
                  5: begin
                     // second group outside the low-surrogate range
                     push_u4(16'($urandom_range(HI_SURR_MIN, HI_SURR_MAX)));
                     v = 16'($urandom);
                     if (v >= LO_SURR_MIN && v <= LO_SURR_MAX) v ^= 16'h8000;
                     push_u4(v);
                  end
                  default: begin
                     // non-hex digit in the second group
                     push_u4(16'($urandom_range(HI_SURR_MIN, HI_SURR_MAX)));
                     push_byte(CH_BSL);
                     push_byte(CH_U);
                     repeat ($urandom_range(0, 3))
                        push_byte(hex_char(4'($urandom_range(0, 15))));
                     push_byte(non_hex());
                  end
               endcase
            end
         end
         // closing quote, now and then a NUL instead
         push_byte($urandom_range(0, 9) == 0 ? 8'h00 : CH_QUOTE);
      end
      total_bytes = body_q.size();

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Every byte taken and every decoded result seen
      while (!(bytes_taken == total_bytes && decoded_q.size() == 0))
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
